FILE: sv/gjs_pkg.sv
// ----------------------------------------------------------------------------
// gjs_pkg
// Shared types, constants and Q32.32 helpers for the Gauss-Jordan solver.
// ----------------------------------------------------------------------------
package gjs_pkg;

  localparam int unsigned DW = 64;
  // 1e-5 in Q32.32, rounded to nearest
  localparam logic [DW-1:0] EPS_Q = 64'd42950;

  typedef enum logic [4:0] {
    S_LOAD,
    S_PIV_RD,
    S_PIV_CHK,
    S_SW_A,
    S_SW_B,
    S_SW_C,
    S_SW_D,
    S_PD_RD,
    S_PD_GET,
    S_ROW_RD,
    S_ROW_GET,
    S_DIV,
    S_ROW_ZERO,
    S_UPD_A,
    S_UPD_B,
    S_MUL,
    S_UPD_C,
    S_UPD_D,
    S_SOL_A,
    S_SOL_B,
    S_SOL_C,
    S_SOL_D,
    S_NOSOL,
    S_OUT
  } gjs_state_e;

  function automatic logic [DW-1:0] mag64(input logic [DW-1:0] x);
    return x[DW-1] ? (~x + 1'b1) : x;
  endfunction

  // signed value from sign and magnitude, saturating
  function automatic logic [DW-1:0] from_mag(input logic neg, input logic [DW-1:0] m,
                                             input logic ovf);
    logic [DW-1:0] r;
    if (neg) begin
      if (ovf || m[DW-1]) r = {1'b1, {(DW-1){1'b0}}};
      else                r = ~m + 1'b1;
    end else begin
      if (ovf || m[DW-1]) r = {1'b0, {(DW-1){1'b1}}};
      else                r = m;
    end
    return r;
  endfunction

  function automatic logic [DW-1:0] qsub(input logic [DW-1:0] a, input logic [DW-1:0] b);
    logic [DW-1:0] r;
    r = a - b;
    if ((a[DW-1] != b[DW-1]) && (r[DW-1] != a[DW-1])) begin
      r = a[DW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

FILE: sv/gauss_jordan_solver_core.sv
// Sequence: n*(n+1) load transfers, then per column a pivot search, a row swap if needed
//   and, per other row, a divide and an update of the remaining columns; then one
//   divide per emitted unknown.
// Throughput: one system at a time; the divider (one quotient bit per cycle) and the 32x32
//   multiplier are shared. Input and config are not ready while a system is solved.
// Reset: async active low; size returns to 16, load restarts, matrix store is not cleared.
// ----------------------------------------------------------------------------
// gauss_jordan_solver_core
// Loads an n x (n+1) augmented matrix, runs Gauss-Jordan elimination with a
// shared divider and multiplier, then emits the unknowns in Q32.32 or a no-solution flag.
// ----------------------------------------------------------------------------
module gauss_jordan_solver_core
  import gjs_pkg::*;
#(
  parameter int unsigned MAX_N = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [4:0]    cfg_matrix_size_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [63:0]   coefficient_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [63:0]   solution_value_o,
  output logic [3:0]    unknown_index_o,
  output logic          no_solution_o,
  output logic          last_result_o
);

  localparam int unsigned RW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int unsigned CW = $clog2(MAX_N + 1);
  localparam int unsigned AW = RW + CW;
  localparam int unsigned DEPTH = 2 ** AW;
  localparam int unsigned DIV_STEPS = 96;

  gjs_state_e state_q, state_d;

  logic [4:0]    size_q;
  logic [CW-1:0] n_act;
  logic [RW-1:0] nm1;
  logic [RW-1:0] row_q, i_q, k_q;
  logic [CW-1:0] col_q;
  logic [63:0]   tmp_q, piv_q, num_q, res_q;
  logic          nosol_q;

  // divider
  logic [63:0]   dn_q, dd_q, r_q, q_q;
  logic          dovf_q, dneg_q, dz_q;
  logic [6:0]    dcnt_q;
  logic          div_start;
  logic [63:0]   div_num, div_den, div_res;
  logic [64:0]   div_rr;

  // multiplier
  logic [63:0]   fm_q, bm_q;
  logic          fneg_q, bneg_q;
  logic [127:0]  acc_q;
  logic [1:0]    mcnt_q;
  logic [31:0]   mul_a, mul_b;
  logic [63:0]   mul_pp;
  logic [127:0]  mul_sh;
  logic [63:0]   prod;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [63:0]   ram_wdata, ram_rdata;

  logic          in_xfer, out_xfer, cfg_xfer;
  logic          load_last, last_j, last_i, col_last, piv_ok, f_small;
  logic [CW-1:0] i_col, j_col;
  logic [RW+3:0] idx_w;

  always_comb begin
    if (size_q == 5'd0) begin
      n_act = CW'(1);
    end else if (32'(size_q) > MAX_N) begin
      n_act = CW'(MAX_N);
    end else begin
      n_act = CW'(size_q);
    end
  end

  assign nm1       = RW'(n_act - 1'b1);
  assign i_col     = CW'(i_q);
  assign j_col     = CW'(row_q);
  assign last_j    = (row_q == nm1);
  assign last_i    = (i_q == nm1);
  assign col_last  = (col_q == n_act);
  assign load_last = last_j && col_last;
  assign piv_ok    = mag64(ram_rdata) > EPS_Q;
  assign f_small   = mag64(div_res) < EPS_Q;

  // a size write takes precedence over a coefficient in the same cycle
  assign cfg_ready_o = (state_q == S_LOAD);
  assign in_ready_o  = (state_q == S_LOAD) && !cfg_valid_i;
  assign out_valid_o = (state_q == S_OUT);
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_xfer    = out_valid_o && out_ready_i;

  assign div_rr  = {r_q, dn_q[63]};
  assign div_res = dz_q ? 64'd0 : from_mag(dneg_q, q_q, dovf_q);

  assign mul_a  = (mcnt_q == 2'd0 || mcnt_q == 2'd1) ? fm_q[63:32] : fm_q[31:0];
  assign mul_b  = (mcnt_q == 2'd0 || mcnt_q == 2'd2) ? bm_q[63:32] : bm_q[31:0];
  assign mul_pp = 64'(mul_a) * 64'(mul_b);
  always_comb begin
    case (mcnt_q)
      2'd0:    mul_sh = {mul_pp, 64'd0};
      2'd1,
      2'd2:    mul_sh = {32'd0, mul_pp, 32'd0};
      default: mul_sh = {64'd0, mul_pp};
    endcase
  end
  assign prod = from_mag(fneg_q ^ bneg_q, acc_q[95:32], |acc_q[127:96]);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD:     if (in_xfer && load_last) state_d = S_PIV_RD;
      S_PIV_RD:   state_d = S_PIV_CHK;
      S_PIV_CHK: begin
        if (piv_ok) state_d = (k_q == i_q) ? S_PD_RD : S_SW_A;
        else if (k_q == nm1) state_d = S_NOSOL;
        else state_d = S_PIV_RD;
      end
      S_SW_A:     state_d = S_SW_B;
      S_SW_B:     state_d = S_SW_C;
      S_SW_C:     state_d = S_SW_D;
      S_SW_D:     state_d = col_last ? S_PD_RD : S_SW_A;
      S_PD_RD:    state_d = S_PD_GET;
      S_PD_GET:   state_d = S_ROW_RD;
      S_ROW_RD: begin
        if (row_q != i_q) state_d = S_ROW_GET;
        else if (!last_j) state_d = S_ROW_RD;
        else state_d = last_i ? S_SOL_A : S_PIV_RD;
      end
      S_ROW_GET:  state_d = S_DIV;
      S_DIV: begin
        if (dcnt_q == 7'(DIV_STEPS - 1)) begin
          state_d = (state_q == S_DIV && nosol_q) ? S_SOL_D : S_ROW_ZERO;
        end
      end
      S_ROW_ZERO: begin
        if (!f_small) state_d = S_UPD_A;
        else if (!last_j) state_d = S_ROW_RD;
        else state_d = last_i ? S_SOL_A : S_PIV_RD;
      end
      S_UPD_A:    state_d = S_UPD_B;
      S_UPD_B:    state_d = S_MUL;
      S_MUL:      if (mcnt_q == 2'd3) state_d = S_UPD_C;
      S_UPD_C:    state_d = S_UPD_D;
      S_UPD_D: begin
        if (!col_last) state_d = S_UPD_A;
        else if (!last_j) state_d = S_ROW_RD;
        else state_d = last_i ? S_SOL_A : S_PIV_RD;
      end
      S_SOL_A:    state_d = S_SOL_B;
      S_SOL_B:    state_d = S_SOL_C;
      S_SOL_C:    state_d = S_DIV;
      S_SOL_D:    state_d = S_OUT;
      S_NOSOL:    state_d = S_OUT;
      S_OUT: begin
        if (out_xfer) state_d = last_result_o ? S_LOAD : S_SOL_A;
      end
      default:    state_d = S_LOAD;
    endcase
  end

  // memory and divider control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {row_q, col_q};
    ram_wdata = ram_rdata;
    ram_raddr = {row_q, col_q};
    div_start = 1'b0;
    div_num   = ram_rdata;
    div_den   = piv_q;
    case (state_q)
      S_LOAD: begin
        ram_we    = in_xfer;
        ram_wdata = coefficient_i;
      end
      S_PIV_RD:   ram_raddr = {k_q, i_col};
      S_SW_A:     ram_raddr = {i_q, col_q};
      S_SW_B:     ram_raddr = {k_q, col_q};
      S_SW_C: begin
        ram_we    = 1'b1;
        ram_waddr = {i_q, col_q};
      end
      S_SW_D: begin
        ram_we    = 1'b1;
        ram_waddr = {k_q, col_q};
        ram_wdata = tmp_q;
      end
      S_PD_RD:    ram_raddr = {i_q, i_col};
      S_ROW_RD:   ram_raddr = {row_q, i_col};
      S_ROW_GET:  div_start = 1'b1;
      S_ROW_ZERO: begin
        ram_we    = 1'b1;
        ram_waddr = {row_q, i_col};
        ram_wdata = 64'd0;
      end
      S_UPD_A:    ram_raddr = {i_q, col_q};
      S_UPD_C:    ram_raddr = {row_q, col_q};
      S_UPD_D: begin
        ram_we    = 1'b1;
        ram_wdata = qsub(ram_rdata, prod);
      end
      S_SOL_A:    ram_raddr = {row_q, n_act};
      S_SOL_B:    ram_raddr = {row_q, j_col};
      S_SOL_C: begin
        div_start = 1'b1;
        div_num   = num_q;
        div_den   = ram_rdata;
      end
      default: ;
    endcase
  end

  // control counters and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      size_q  <= 5'd16;
      row_q   <= '0;
      col_q   <= '0;
      i_q     <= '0;
      k_q     <= '0;
      nosol_q <= 1'b0;
      dcnt_q  <= '0;
      mcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_LOAD: begin
          nosol_q <= 1'b0;
          if (cfg_xfer) begin
            row_q <= '0;
            col_q <= '0;
          end else if (in_xfer) begin
            if (load_last) begin
              row_q <= '0;
              col_q <= '0;
              i_q   <= '0;
              k_q   <= '0;
            end else if (col_last) begin
              row_q <= row_q + 1'b1;
              col_q <= '0;
            end else begin
              col_q <= col_q + 1'b1;
            end
          end
        end
        S_PIV_CHK: begin
          if (!piv_ok) k_q <= k_q + 1'b1;
          col_q <= i_col;
        end
        S_SW_D:     col_q <= col_q + 1'b1;
        S_PD_GET:   row_q <= '0;
        S_ROW_GET:  dcnt_q <= '0;
        S_SOL_C: begin
          dcnt_q  <= '0;
          nosol_q <= 1'b1;  // marks divider use for a solution
        end
        S_DIV:      dcnt_q <= dcnt_q + 1'b1;
        S_UPD_B:    mcnt_q <= '0;
        S_MUL:      mcnt_q <= mcnt_q + 1'b1;
        S_UPD_D:    col_q <= col_q + 1'b1;
        S_SOL_D:    nosol_q <= 1'b0;
        S_NOSOL:    nosol_q <= 1'b1;
        S_OUT: begin
          if (out_xfer) begin
            if (last_result_o) begin
              row_q   <= '0;
              col_q   <= '0;
              nosol_q <= 1'b0;
            end else begin
              row_q <= row_q + 1'b1;
            end
          end
        end
        default: ;
      endcase
      if (state_q == S_ROW_ZERO && !f_small) col_q <= CW'(i_col + 1'b1);
      // shared end-of-row step
      if ((state_q == S_ROW_RD && row_q == i_q) ||
          (state_q == S_ROW_ZERO && f_small) ||
          (state_q == S_UPD_D && col_last)) begin
        if (!last_j) begin
          row_q <= row_q + 1'b1;
        end else begin
          row_q <= '0;
          i_q   <= i_q + 1'b1;
          k_q   <= i_q + 1'b1;
        end
      end
      if (cfg_xfer) size_q <= cfg_matrix_size_i;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_SW_B:     tmp_q <= ram_rdata;
      S_PD_GET:   piv_q <= ram_rdata;
      S_ROW_ZERO: begin
        fm_q   <= mag64(div_res);
        fneg_q <= div_res[63];
      end
      S_UPD_B: begin
        bm_q   <= mag64(ram_rdata);
        bneg_q <= ram_rdata[63];
        acc_q  <= '0;
      end
      S_MUL:      acc_q <= acc_q + mul_sh;
      S_SOL_B:    num_q <= ram_rdata;
      S_SOL_D:    res_q <= div_res;
      S_NOSOL:    res_q <= 64'd0;
      default: ;
    endcase
    if (div_start) begin
      dn_q   <= mag64(div_num);
      dd_q   <= mag64(div_den);
      dneg_q <= div_num[63] ^ div_den[63];
      dz_q   <= (div_den == 64'd0);
      r_q    <= '0;
      q_q    <= '0;
      dovf_q <= 1'b0;
    end else if (state_q == S_DIV) begin
      dn_q   <= {dn_q[62:0], 1'b0};
      dovf_q <= dovf_q | q_q[63];
      if (div_rr >= {1'b0, dd_q}) begin
        r_q <= 64'(div_rr - {1'b0, dd_q});
        q_q <= {q_q[62:0], 1'b1};
      end else begin
        r_q <= div_rr[63:0];
        q_q <= {q_q[62:0], 1'b0};
      end
    end
  end

  gjs_ram #(
    .WIDTH(64),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign idx_w            = (RW + 4)'(row_q);
  assign solution_value_o = res_q;
  assign no_solution_o    = nosol_q;
  assign unknown_index_o  = nosol_q ? 4'd0 : idx_w[3:0];
  assign last_result_o    = nosol_q || last_j;

  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input ready while result pending");
  a_nosol_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && no_solution_o) |-> (last_result_o && solution_value_o == 64'd0))
    else $error("no-solution result malformed");
  a_out_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == S_SOL_D || $past(state_q) == S_NOSOL))
    else $error("result raised from wrong step");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(solution_value_o)))
    else $error("pending result changed");

endmodule

FILE: sv/gjs_ram.sv
// ----------------------------------------------------------------------------
// gjs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gjs_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
